// ===== rtl/hub_label_distance_query_assert.svh =====
// Assertion macros for the hub label query RTL.
// Included by hldq_back, which checks its own control logic; no other dependencies.
`ifndef HUB_LABEL_DISTANCE_QUERY_ASSERT_SVH
`define HUB_LABEL_DISTANCE_QUERY_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define HLDQ_ASSERT_IMP(name, ck, rs, pre, post) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("hub label query: check failed");
// Next-cycle implication, disabled while reset is high.
`define HLDQ_ASSERT_NEXT(name, ck, rs, pre, post) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("hub label query: check failed");
`else
`define HLDQ_ASSERT_IMP(name, ck, rs, pre, post)
`define HLDQ_ASSERT_NEXT(name, ck, rs, pre, post)
`endif
`endif

// ===== rtl/hldq_pkg.sv =====
// Shared types and constants of the hub label distance query block.
// No dependencies; imported by hldq_front, hldq_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hldq_pkg;

  localparam int TYPE_W       = 2;
  localparam int VTX_FIELD_W  = 10;
  localparam int HUB_W        = 10;
  localparam int HUB_COUNT    = 1024;
  localparam int DIST_FIELD_W = 24;
  localparam int STATUS_W     = 2;
  localparam int OUT_DIST_W   = 25;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [OUT_DIST_W-1:0] OUT_DIST_NONE = 25'h1FF_FFFF;
  localparam logic [OUT_DIST_W-1:0] OUT_DIST_MAX  = 25'h1FF_FFFE;

  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  typedef enum logic [TYPE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [TYPE_W-1:0]       req_type;
    logic [VTX_FIELD_W-1:0]  target_vertex;
    logic [VTX_FIELD_W-1:0]  other_vertex;
    logic [HUB_W-1:0]        hub_id;
    logic [DIST_FIELD_W-1:0] hub_distance;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_DIST_W-1:0] distance;
  } res_t;

  // Classified request as it travels from the front part to the back part.
  typedef struct packed {
    op_t                     op;
    logic                    tv_ok;
    logic                    ov_ok;
    logic [VTX_FIELD_W-1:0]  target_vertex;
    logic [VTX_FIELD_W-1:0]  other_vertex;
    logic [HUB_W-1:0]        hub_id;
    logic [DIST_FIELD_W-1:0] hub_distance;
  } cmd_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_AP_RD,
    S_AP_WR,
    S_QA_RD,
    S_QB_RD,
    S_QN_WAIT,
    S_PASS_A,
    S_PASS_B,
    S_PASS_C,
    S_RESULT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/hldq_fifo.sv =====
// Small register queue used between the parts of the hub label query block.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module hldq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hldq_front.sv =====
// Front part: takes requests, decodes the type and range-checks the vertices.
// Depends on hldq_pkg and hldq_fifo, which holds the decoded commands.
`timescale 1ns / 1ps
`default_nettype none

module hldq_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  hldq_pkg::req_t  request,
  output logic            cmd_valid,
  output hldq_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);

  import hldq_pkg::*;

  // Wide enough to hold the largest vertex count.
  localparam int VCMP_W = 17;

  cmd_t                in_cmd;
  logic [$bits(cmd_t)-1:0] q_rdata;
  logic                q_empty;

  always_comb begin
    in_cmd.op            = op_t'(request.req_type);
    in_cmd.tv_ok         = VCMP_W'(request.target_vertex) < VCMP_W'(MAX_VERTICES);
    in_cmd.ov_ok         = VCMP_W'(request.other_vertex) < VCMP_W'(MAX_VERTICES);
    in_cmd.target_vertex = request.target_vertex;
    in_cmd.other_vertex  = request.other_vertex;
    in_cmd.hub_id        = request.hub_id;
    in_cmd.hub_distance  = request.hub_distance;
  end

  hldq_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (in_cmd),
    .pop   (cmd_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_rdata);

endmodule

`default_nettype wire

// ===== rtl/hldq_back.sv =====
// Back part: label store, per-vertex counts, hub scratch table and the query engine.
// Depends on hldq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "hub_label_distance_query_assert.svh"

module hldq_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_LABELS   = 64,
  parameter int DIST_BITS    = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  hldq_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_push,
  output hldq_pkg::res_t res,
  input  logic           res_full
);

  import hldq_pkg::*;

  localparam int VTX_W     = $clog2(MAX_VERTICES);
  localparam int SLOT_W    = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int CNT_W     = $clog2(MAX_LABELS + 1);
  localparam int LBL_AW    = VTX_W + SLOT_W;
  localparam int LBL_DEPTH = MAX_VERTICES * (2 ** SLOT_W);
  localparam int SUM_W     = DIST_BITS + 1;
  localparam int CMP_W     = SUM_W + OUT_DIST_W;
  localparam int SWEEP_N   = (MAX_VERTICES > HUB_COUNT) ? MAX_VERTICES : HUB_COUNT;
  localparam int SW_W      = $clog2(SWEEP_N);

  // Memories.
  logic [CNT_W-1:0]     cnt_mem      [MAX_VERTICES];
  logic [HUB_W-1:0]     lbl_hub_mem  [LBL_DEPTH];
  logic [DIST_BITS-1:0] lbl_dist_mem [LBL_DEPTH];
  logic                 tbl_vld_mem  [HUB_COUNT];
  logic [DIST_BITS-1:0] tbl_dist_mem [HUB_COUNT];

  // Control registers.
  back_state_t state;
  back_state_t state_next;
  logic [SW_W-1:0]  idx;
  logic             reply;
  logic [CNT_W-1:0] pass_i;
  logic             v1;
  logic             v2;
  logic             fw_v;

  // Payload registers.
  cmd_t                 cur;
  res_t                 res_q;
  logic [CNT_W-1:0]     na;
  logic [CNT_W-1:0]     nb;
  logic [HUB_W-1:0]     h2;
  logic [DIST_BITS-1:0] d2;
  logic [HUB_W-1:0]     fw_hub;
  logic [DIST_BITS-1:0] fw_dist;
  logic                 found;
  logic [SUM_W-1:0]     least;

  // Registered read data.
  logic [CNT_W-1:0]     cnt_q;
  logic [HUB_W-1:0]     lbl_q_hub;
  logic [DIST_BITS-1:0] lbl_q_dist;
  logic                 tbl_q_vld;
  logic [DIST_BITS-1:0] tbl_q_dist;

  // Combinational control.
  logic [VTX_W-1:0]     tv_idx;
  logic [VTX_W-1:0]     ov_idx;
  logic                 in_pass;
  logic [VTX_W-1:0]     pass_v;
  logic [CNT_W-1:0]     pass_n;
  logic                 issue;
  logic                 pipe_idle;
  logic                 sweep_last;
  logic                 ap_ok;
  logic [CNT_W-1:0]     nb_now;
  logic                 query_done;
  logic                 fwd;
  logic                 old_v;
  logic [DIST_BITS-1:0] old_d;
  logic [DIST_BITS-1:0] new_d;
  logic [SUM_W-1:0]     cand;
  logic                 b_hit;
  logic [OUT_DIST_W-1:0] dist_fmt;

  logic                 cnt_we;
  logic [VTX_W-1:0]     cnt_waddr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic [VTX_W-1:0]     cnt_raddr;
  logic                 lbl_we;
  logic [LBL_AW-1:0]    lbl_waddr;
  logic [LBL_AW-1:0]    lbl_raddr;
  logic                 tbl_we;
  logic [HUB_W-1:0]     tbl_waddr;
  logic                 tbl_wvld;
  logic [DIST_BITS-1:0] tbl_wdist;

  assign tv_idx     = VTX_W'(cur.target_vertex);
  assign ov_idx     = VTX_W'(cur.other_vertex);
  assign in_pass    = (state == S_PASS_A) || (state == S_PASS_B) || (state == S_PASS_C);
  assign pass_v     = (state == S_PASS_B) ? ov_idx : tv_idx;
  assign pass_n     = (state == S_PASS_B) ? nb : na;
  assign issue      = in_pass && (pass_i < pass_n);
  assign pipe_idle  = !issue && !v1 && !v2;
  assign sweep_last = (idx == SW_W'(SWEEP_N - 1));
  assign ap_ok      = cur.tv_ok && (cnt_q < CNT_W'(MAX_LABELS));
  assign nb_now     = cur.ov_ok ? cnt_q : '0;
  assign query_done = ((state == S_QN_WAIT) || (state == S_PASS_C)) && (state_next == S_RESULT);

  // Pass A keeps the least distance of list A per hub; the previous write is
  // forwarded because its read was issued in the same cycle.
  assign fwd   = fw_v && (fw_hub == h2);
  assign old_v = fwd ? 1'b1 : tbl_q_vld;
  assign old_d = fwd ? fw_dist : tbl_q_dist;
  assign new_d = (old_v && (old_d < d2)) ? old_d : d2;

  // Pass B adds the list B distance to the stored minimum for the same hub.
  assign cand  = SUM_W'(tbl_q_dist) + SUM_W'(d2);
  assign b_hit = (state == S_PASS_B) && v2 && tbl_q_vld && (!found || (cand < least));

  assign dist_fmt = (CMP_W'(least) > CMP_W'(OUT_DIST_MAX)) ? OUT_DIST_MAX
                                                           : OUT_DIST_W'(least);

  // Memory port selection.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = tv_idx;
    cnt_wdata = cnt_q + 1'b1;
    if (state == S_SWEEP) begin
      cnt_we    = (SW_W + 1)'(idx) < (SW_W + 1)'(MAX_VERTICES);
      cnt_waddr = idx[VTX_W-1:0];
      cnt_wdata = '0;
    end else if (state == S_AP_WR) begin
      cnt_we = ap_ok;
    end
  end

  assign cnt_raddr = (state == S_QB_RD) ? ov_idx : tv_idx;
  assign lbl_we    = (state == S_AP_WR) && ap_ok;
  assign lbl_waddr = {tv_idx, cnt_q[SLOT_W-1:0]};
  assign lbl_raddr = {pass_v, pass_i[SLOT_W-1:0]};

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = h2;
    tbl_wvld  = 1'b0;
    tbl_wdist = new_d;
    if (state == S_SWEEP) begin
      tbl_we    = (SW_W + 1)'(idx) < (SW_W + 1)'(HUB_COUNT);
      tbl_waddr = idx[HUB_W-1:0];
    end else if (state == S_PASS_A) begin
      tbl_we   = v2;
      tbl_wvld = 1'b1;
    end else if (state == S_PASS_C) begin
      tbl_we = v2;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    case (state)
      S_SWEEP: begin
        if (sweep_last) begin
          state_next = reply ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_APPEND: state_next = S_AP_RD;
            OP_QUERY:  state_next = S_QA_RD;
            OP_CLEAR:  state_next = S_SWEEP;
            default:   state_next = S_RESULT;
          endcase
        end
      end
      S_AP_RD:  state_next = S_AP_WR;
      S_AP_WR:  state_next = S_RESULT;
      S_QA_RD:  state_next = S_QB_RD;
      S_QB_RD:  state_next = S_QN_WAIT;
      S_QN_WAIT: begin
        state_next = ((na == '0) || (nb_now == '0)) ? S_RESULT : S_PASS_A;
      end
      S_PASS_A: begin
        if (pipe_idle) begin
          state_next = S_PASS_B;
        end
      end
      S_PASS_B: begin
        if (pipe_idle) begin
          state_next = S_PASS_C;
        end
      end
      S_PASS_C: begin
        if (pipe_idle) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      reply  <= 1'b0;
      pass_i <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      fw_v   <= 1'b0;
    end else begin
      if (state == S_SWEEP) begin
        idx <= sweep_last ? '0 : idx + 1'b1;
      end
      if (cmd_pop) begin
        reply <= (cmd.op == OP_CLEAR);
      end
      if (state != state_next) begin
        pass_i <= '0;
      end else if (issue) begin
        pass_i <= pass_i + 1'b1;
      end
      v1   <= issue;
      v2   <= v1;
      fw_v <= (state == S_PASS_A) && v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur   <= cmd;
      res_q <= '{status: ST_OK, distance: '0};
    end
    if ((state == S_AP_WR) && !ap_ok) begin
      res_q.status <= ST_FULL;
    end
    if (state == S_QA_RD) begin
      found <= 1'b0;
    end
    if (state == S_QB_RD) begin
      na <= cur.tv_ok ? cnt_q : '0;
    end
    if (state == S_QN_WAIT) begin
      nb <= nb_now;
    end
    if (b_hit) begin
      found <= 1'b1;
      least <= cand;
    end
    if (query_done) begin
      if (found) begin
        res_q.status   <= ST_OK;
        res_q.distance <= dist_fmt;
      end else begin
        res_q.status   <= ST_NOT_FOUND;
        res_q.distance <= OUT_DIST_NONE;
      end
    end
    h2      <= lbl_q_hub;
    d2      <= lbl_q_dist;
    fw_hub  <= h2;
    fw_dist <= tbl_wdist;
  end

  // Count memory.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  // Label store.
  always_ff @(posedge clk) begin
    if (lbl_we) begin
      lbl_hub_mem[lbl_waddr]  <= cur.hub_id;
      lbl_dist_mem[lbl_waddr] <= DIST_BITS'(cur.hub_distance);
    end
    lbl_q_hub  <= lbl_hub_mem[lbl_raddr];
    lbl_q_dist <= lbl_dist_mem[lbl_raddr];
  end

  // Hub scratch table, indexed by hub id.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_vld_mem[tbl_waddr]  <= tbl_wvld;
      tbl_dist_mem[tbl_waddr] <= tbl_wdist;
    end
    tbl_q_vld  <= tbl_vld_mem[lbl_q_hub];
    tbl_q_dist <= tbl_dist_mem[lbl_q_hub];
  end

  assign res = res_q;

  `HLDQ_ASSERT_IMP(a_pass_bound, clk, rst, in_pass, pass_i <= pass_n)
  `HLDQ_ASSERT_IMP(a_pass_drained, clk, rst, in_pass && (state_next != state), !v1 && !v2)
  `HLDQ_ASSERT_IMP(a_none_code, clk, rst,
                   res_push && (res.status == ST_NOT_FOUND), res.distance == OUT_DIST_NONE)
  `HLDQ_ASSERT_IMP(a_found_dist, clk, rst,
                   res_push && (res.status == ST_OK), res.distance != OUT_DIST_NONE)
  `HLDQ_ASSERT_NEXT(a_pop_starts, clk, rst, cmd_pop, state != S_IDLE)

endmodule

`default_nettype wire

// ===== rtl/hub_label_distance_query.sv =====
// Top level of the hub label distance query block.
// Depends on hldq_pkg, hldq_front, hldq_back and hldq_fifo.
//
//   channel   handshake              payload
//   request   push / full            request  (hldq_pkg::req_t)
//   response  empty / pop            response (hldq_pkg::res_t)
//
// A query walks list A twice and list B once through the single label store read port,
// a label a cycle. A clear sweeps max(MAX_VERTICES, 1024) entries, clearing one count
// and one scratch entry a cycle; the same sweep runs after reset while requests fill
// the command queue. Either side may stall freely: queues sit in front of and behind
// the engine.
`timescale 1ns / 1ps
`default_nettype none

module hub_label_distance_query #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_LABELS   = 64,
  parameter int DIST_BITS    = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  hldq_pkg::req_t request,
  output logic           empty,
  input  logic           pop,
  output hldq_pkg::res_t response
);

  import hldq_pkg::*;

  // Decoded requests waiting for the engine.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Finished responses on their way to the output queue.
  res_t res;
  logic res_push;
  logic res_full;
  logic [$bits(res_t)-1:0] res_rdata;

  // The front part decodes each request and holds it in a short queue, so the
  // requester can keep pushing while a long query runs.
  hldq_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // The back part owns the label store and works through one request at a time.
  hldq_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_LABELS  (MAX_LABELS),
    .DIST_BITS   (DIST_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // Output queue: the oldest response is shown while empty is low.
  hldq_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (res_rdata)
  );

  assign response = res_t'(res_rdata);

endmodule

`default_nettype wire
